>>> rtl/tcce_pkg.sv
// Package for the text console cursor engine.
// Holds character codes, register indexes, the queue entry type and the lead byte decoder.
// No dependencies.
package tcce_pkg;

    // character codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    // result actions
    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_SCROLL = 1'b1;

    // configuration register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // register reset values
    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd25;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one queued byte's work: an optional draw, then an optional scroll
    typedef struct packed {
        logic        has_draw;
        logic [31:0] glyph_bytes;
        logic [2:0]  glyph_length;
        logic [7:0]  cell_column;
        logic [7:0]  cell_row;
        logic        has_scroll;
    } entry_t;

    // number of bytes a UTF-8 lead byte announces, 1 for anything else
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd1;
        if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

>>> rtl/tcce_front.sv
// Front part: accepts bytes, collects multi-byte glyphs and moves the cursor.
// Holds the screen size registers; pushes one entry per byte that yields results.
// Depends on tcce_pkg.
module tcce_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_out_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 queue_full,
    output logic                 push_valid,
    output tcce_pkg::entry_t     push_entry
);

    logic [7:0]  columns_reg;
    logic [7:0]  rows_reg;
    logic [7:0]  cursor_column_reg, cursor_column_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;
    logic [23:0] partial_glyph_reg, partial_glyph_next;
    logic [1:0]  bytes_collected_reg, bytes_collected_next;
    logic [2:0]  bytes_expected_reg, bytes_expected_next;

    logic        accept;
    logic [7:0]  eff_columns;
    logic [7:0]  eff_rows;
    logic [31:0] glyph;
    logic [2:0]  lead_len;
    logic        do_draw;
    logic [31:0] draw_bytes;
    logic [2:0]  draw_len;
    logic [1:0]  draw_adv;
    logic        to_next_row;
    logic [8:0]  adv_column;
    logic [8:0]  adv_row;
    tcce_pkg::entry_t entry;

    assign cfg_ready = 1'b1;
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;

    // a zero size acts as one
    assign eff_columns = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
    assign eff_rows    = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign lead_len    = tcce_pkg::lead_length(s_out_byte);

    // merge the new byte into the pending glyph
    always_comb begin
        case (bytes_collected_reg)
            2'd0:    glyph = {8'd0, partial_glyph_reg} | {24'd0, s_out_byte};
            2'd1:    glyph = {8'd0, partial_glyph_reg} | {16'd0, s_out_byte, 8'd0};
            2'd2:    glyph = {8'd0, partial_glyph_reg} | {8'd0, s_out_byte, 16'd0};
            default: glyph = {s_out_byte, partial_glyph_reg};
        endcase
    end

    // classify the byte and compute the next cursor state
    always_comb begin
        cursor_column_next   = cursor_column_reg;
        cursor_row_next      = cursor_row_reg;
        partial_glyph_next   = partial_glyph_reg;
        bytes_collected_next = bytes_collected_reg;
        bytes_expected_next  = bytes_expected_reg;
        do_draw              = 1'b0;
        draw_bytes           = {24'd0, s_out_byte};
        draw_len             = 3'd1;
        draw_adv             = 2'd1;
        to_next_row          = 1'b0;
        entry                = '0;
        adv_column           = 9'd0;
        adv_row              = 9'd0;

        if (bytes_expected_reg != 3'd0) begin
            if ({1'b0, bytes_collected_reg} + 3'd1 >= bytes_expected_reg) begin
                partial_glyph_next   = 24'd0;
                bytes_collected_next = 2'd0;
                bytes_expected_next  = 3'd0;
                do_draw              = 1'b1;
                draw_bytes           = glyph;
                draw_len             = bytes_expected_reg;
                draw_adv             = (bytes_expected_reg >= 3'd3) ? 2'd2 : 2'd1;
            end else begin
                partial_glyph_next   = glyph[23:0];
                bytes_collected_next = bytes_collected_reg + 2'd1;
            end
        end else if (lead_len > 3'd1) begin
            partial_glyph_next   = {16'd0, s_out_byte};
            bytes_collected_next = 2'd1;
            bytes_expected_next  = lead_len;
        end else if (s_out_byte == tcce_pkg::CH_NEWLINE) begin
            to_next_row = 1'b1;
        end else if (s_out_byte == tcce_pkg::CH_RETURN) begin
            cursor_column_next = 8'd0;
        end else if (s_out_byte == tcce_pkg::CH_BACKSPACE) begin
            if (cursor_column_reg != 8'd0) begin
                cursor_column_next  = cursor_column_reg - 8'd1;
                entry.has_draw      = 1'b1;
                entry.glyph_bytes   = {24'd0, tcce_pkg::CH_BLANK};
                entry.glyph_length  = 3'd1;
                entry.cell_column   = cursor_column_reg - 8'd1;
                entry.cell_row      = cursor_row_reg;
            end
        end else begin
            do_draw = 1'b1;
        end

        // draw at the cursor and advance, wrapping to the next row
        if (do_draw) begin
            entry.has_draw     = 1'b1;
            entry.glyph_bytes  = draw_bytes;
            entry.glyph_length = draw_len;
            entry.cell_column  = cursor_column_reg;
            entry.cell_row     = cursor_row_reg;
            adv_column = {1'b0, cursor_column_reg} + {7'd0, draw_adv};
            if (adv_column >= {1'b0, eff_columns}) begin
                to_next_row = 1'b1;
            end else begin
                cursor_column_next = adv_column[7:0];
            end
        end

        // next row, scrolling past the bottom
        if (to_next_row) begin
            cursor_column_next = 8'd0;
            adv_row = {1'b0, cursor_row_reg} + 9'd1;
            if (adv_row >= {1'b0, eff_rows}) begin
                cursor_row_next  = eff_rows - 8'd1;
                entry.has_scroll = 1'b1;
            end else begin
                cursor_row_next = adv_row[7:0];
            end
        end
    end

    assign push_valid = accept && (entry.has_draw || entry.has_scroll);
    assign push_entry = entry;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= tcce_pkg::COLUMNS_RESET;
            rows_reg    <= tcce_pkg::ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == tcce_pkg::REG_COLUMNS) begin
                columns_reg <= cfg_data;
            end else begin
                rows_reg <= cfg_data;
            end
        end
    end

    // cursor and glyph collection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_column_reg   <= 8'd0;
            cursor_row_reg      <= 8'd0;
            partial_glyph_reg   <= 24'd0;
            bytes_collected_reg <= 2'd0;
            bytes_expected_reg  <= 3'd0;
        end else if (accept) begin
            cursor_column_reg   <= cursor_column_next;
            cursor_row_reg      <= cursor_row_next;
            partial_glyph_reg   <= partial_glyph_next;
            bytes_collected_reg <= bytes_collected_next;
            bytes_expected_reg  <= bytes_expected_next;
        end
    end

endmodule

>>> rtl/tcce_queue.sv
// Short queue of entries between the front and back parts.
// Register storage, one push and one pop per cycle, a push only while not full, a pop only while not empty.
// Depends on tcce_pkg.
module tcce_queue #(
    parameter int DEPTH = tcce_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  tcce_pkg::entry_t     push_entry,
    input  logic                 pop,
    output tcce_pkg::entry_t     head_entry,
    output logic                 empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tcce_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == FULL_CNT);
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = mem_reg[rd_ptr_reg];

    // advance pointers with wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/tcce_back.sv
// Back part: turns queued entries into result transactions, draw first, then scroll.
// Drives the registered result channel.
// Depends on tcce_pkg.
module tcce_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcce_pkg::entry_t     head_entry,
    input  logic                 queue_empty,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_action,
    output logic [31:0]          m_glyph_bytes,
    output logic [2:0]           m_glyph_length,
    output logic [7:0]           m_cell_column,
    output logic [7:0]           m_cell_row,
    output logic                 m_last_of_run
);

    logic        m_valid_reg, m_valid_next;
    logic        action_reg, action_next;
    logic [31:0] glyph_bytes_reg, glyph_bytes_next;
    logic [2:0]  glyph_length_reg, glyph_length_next;
    logic [7:0]  cell_column_reg, cell_column_next;
    logic [7:0]  cell_row_reg, cell_row_next;
    logic        last_reg, last_next;
    logic        phase_reg, phase_next;
    logic        load;

    assign load = !m_valid_reg || m_ready;

    // pick the next result from the head entry
    always_comb begin
        m_valid_next      = m_valid_reg;
        action_next       = action_reg;
        glyph_bytes_next  = glyph_bytes_reg;
        glyph_length_next = glyph_length_reg;
        cell_column_next  = cell_column_reg;
        cell_row_next     = cell_row_reg;
        last_next         = last_reg;
        phase_next        = phase_reg;
        pop               = 1'b0;
        if (load) begin
            m_valid_next = !queue_empty;
            if (!queue_empty) begin
                if (!phase_reg && head_entry.has_draw) begin
                    action_next       = tcce_pkg::ACT_DRAW;
                    glyph_bytes_next  = head_entry.glyph_bytes;
                    glyph_length_next = head_entry.glyph_length;
                    cell_column_next  = head_entry.cell_column;
                    cell_row_next     = head_entry.cell_row;
                    last_next         = !head_entry.has_scroll;
                    phase_next        = head_entry.has_scroll;
                    pop               = !head_entry.has_scroll;
                end else begin
                    action_next       = tcce_pkg::ACT_SCROLL;
                    glyph_bytes_next  = 32'd0;
                    glyph_length_next = 3'd0;
                    cell_column_next  = 8'd0;
                    cell_row_next     = 8'd0;
                    last_next         = 1'b1;
                    phase_next        = 1'b0;
                    pop               = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        action_reg       <= action_next;
        glyph_bytes_reg  <= glyph_bytes_next;
        glyph_length_reg <= glyph_length_next;
        cell_column_reg  <= cell_column_next;
        cell_row_reg     <= cell_row_next;
        last_reg         <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_action       = action_reg;
    assign m_glyph_bytes  = glyph_bytes_reg;
    assign m_glyph_length = glyph_length_reg;
    assign m_cell_column  = cell_column_reg;
    assign m_cell_row     = cell_row_reg;
    assign m_last_of_run  = last_reg;

`ifndef NO_ASSERTIONS
    // only a draw can be followed by more results of the same byte
    a_mid_run_is_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !last_reg |-> action_reg == tcce_pkg::ACT_DRAW && phase_reg)
        else $error("non-final result is not a draw");
    // scroll results carry no glyph and close the run
    a_scroll_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && action_reg == tcce_pkg::ACT_SCROLL |->
            glyph_length_reg == 3'd0 && last_reg)
        else $error("scroll result carries glyph data");
    // a half-served entry stays at the head of the queue
    a_phase_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> !queue_empty && head_entry.has_scroll)
        else $error("pending scroll without a queued entry");
    // draws always carry one to four bytes
    a_draw_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && action_reg == tcce_pkg::ACT_DRAW |->
            glyph_length_reg != 3'd0 && !glyph_length_reg[2] || glyph_length_reg == 3'd4)
        else $error("draw with bad glyph length");
`endif

endmodule

>>> rtl/text_console_cursor_engine_top.sv
// Text console cursor engine: one byte per cycle in while the entry queue is not full, one result
// per cycle out while the receiver is ready; each result passes through the entry queue and then
// the output register. A byte giving a draw and a scroll yields two results, the difference
// absorbed by the entry queue between the cursor front part and the result back part.
// Reset (aresetn low, synchronous): cursor to 0,0, no pending glyph, 80 columns, 25 rows,
// queue and output register empty.
module text_console_cursor_engine_top #(
    parameter int QUEUE_DEPTH = tcce_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_out_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_action,
    output logic [31:0] m_glyph_bytes,
    output logic [2:0]  m_glyph_length,
    output logic [7:0]  m_cell_column,
    output logic [7:0]  m_cell_row,
    output logic        m_last_of_run
);

    tcce_pkg::entry_t push_entry;
    tcce_pkg::entry_t head_entry;
    logic             push_valid;
    logic             queue_full;
    logic             queue_empty;
    logic             pop;

    tcce_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_out_byte (s_out_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    tcce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    tcce_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_entry     (head_entry),
        .queue_empty    (queue_empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_glyph_bytes  (m_glyph_bytes),
        .m_glyph_length (m_glyph_length),
        .m_cell_column  (m_cell_column),
        .m_cell_row     (m_cell_row),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

>>> sim/tb_text_console_cursor_engine_top.sv
// Testbench for text_console_cursor_engine_top: drives UTF-8 byte streams under many screen
// sizes and checks every draw and scroll result against a cursor model kept in the bench.
// Depends on rtl/tcce_pkg.sv and rtl/text_console_cursor_engine_top.sv.
module tb_text_console_cursor_engine_top;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int SETTLE_TICKS = 10;

    typedef struct packed {
        logic        action;
        logic [31:0] glyph_bytes;
        logic [2:0]  glyph_length;
        logic [7:0]  cell_column;
        logic [7:0]  cell_row;
        logic        last_of_run;
    } console_result_t;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [7:0]  s_out_byte = 8'h00;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic        cfg_index  = tcce_pkg::REG_COLUMNS;
    logic [7:0]  cfg_data   = 8'h00;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic        m_action;
    logic [31:0] m_glyph_bytes;
    logic [2:0]  m_glyph_length;
    logic [7:0]  m_cell_column;
    logic [7:0]  m_cell_row;
    logic        m_last_of_run;

    // cursor model state and its copy of the screen size registers
    logic [7:0]  model_cols = tcce_pkg::COLUMNS_RESET;
    logic [7:0]  model_rows = tcce_pkg::ROWS_RESET;
    logic [7:0]  cur_col    = 8'd0;
    logic [7:0]  cur_row    = 8'd0;
    logic [23:0] glyph_acc  = 24'd0;
    logic [1:0]  glyph_got  = 2'd0;
    logic [2:0]  glyph_need = 3'd0;

    console_result_t run_results[$];
    console_result_t expected_results[$];
    logic [7:0]      pending_bytes[$];

    logic [7:0] opening_text[$] = '{
        "A", "B", "C", "D", 8'h00, 8'hFF, 8'h80, 8'hF8,
        tcce_pkg::CH_NEWLINE, tcce_pkg::CH_RETURN, tcce_pkg::CH_BACKSPACE, "x",
        tcce_pkg::CH_BACKSPACE,
        8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
        8'hF7, 8'hBF, tcce_pkg::CH_RETURN, tcce_pkg::CH_BACKSPACE, 8'hDF,
        tcce_pkg::CH_NEWLINE
    };

    int unsigned mismatch_count = 0;
    int unsigned cfg_writes     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_asked     = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    logic        calm           = 1'b0;
    logic        in_taken       = 1'b0;

    text_console_cursor_engine_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_out_byte    (s_out_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_glyph_bytes (m_glyph_bytes),
        .m_glyph_length(m_glyph_length),
        .m_cell_column (m_cell_column),
        .m_cell_row    (m_cell_row),
        .m_last_of_run (m_last_of_run)
    );

    always #4 aclk = ~aclk;

    // a size register of zero behaves as one
    function automatic int usable(logic [7:0] v);
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    // move to column 0 of the next row, scrolling when the bottom is passed
    task automatic wrap_line();
        int r;
        r = int'(cur_row) + 1;
        cur_col = 8'd0;
        if (r >= usable(model_rows)) begin
            cur_row = 8'(usable(model_rows) - 1);
            run_results.push_back('{tcce_pkg::ACT_SCROLL, 32'd0, 3'd0, 8'd0, 8'd0, 1'b0});
        end else begin
            cur_row = 8'(r);
        end
    endtask

    // draw at the cursor, then advance by the glyph's display width
    task automatic draw_glyph(logic [31:0] bytes, logic [2:0] len, int adv);
        int c;
        run_results.push_back('{tcce_pkg::ACT_DRAW, bytes, len, cur_col, cur_row, 1'b0});
        c = int'(cur_col) + adv;
        if (c >= usable(model_cols)) begin
            wrap_line();
        end else begin
            cur_col = 8'(c);
        end
    endtask

    // work out the results one accepted byte causes and queue them
    task automatic predict_console_results(input logic [7:0] b);
        logic [31:0] glyph;
        logic [2:0]  need;
        int          pos;
        run_results.delete();
        if (glyph_need != 3'd0) begin
            // any byte after a lead byte joins the glyph
            pos   = int'(glyph_got);
            glyph = {8'h00, glyph_acc} | (32'(b) << (8 * pos));
            if (pos + 1 >= int'(glyph_need)) begin
                need       = glyph_need;
                glyph_acc  = 24'd0;
                glyph_got  = 2'd0;
                glyph_need = 3'd0;
                draw_glyph(glyph, need, (need >= 3'd3) ? 2 : 1);
            end else begin
                glyph_acc = glyph[23:0];
                glyph_got = 2'(pos + 1);
            end
        end else if (b >= 8'hC0 && b <= 8'hF7) begin
            glyph_acc  = {16'd0, b};
            glyph_got  = 2'd1;
            glyph_need = (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : 3'd4;
        end else begin
            case (b)
                tcce_pkg::CH_NEWLINE: begin
                    wrap_line();
                end
                tcce_pkg::CH_RETURN: begin
                    cur_col = 8'd0;
                end
                tcce_pkg::CH_BACKSPACE: begin
                    if (cur_col != 8'd0) begin
                        cur_col = cur_col - 8'd1;
                        run_results.push_back('{tcce_pkg::ACT_DRAW,
                                                32'(tcce_pkg::CH_BLANK), 3'd1,
                                                cur_col, cur_row, 1'b0});
                    end
                end
                default: begin
                    draw_glyph(32'(b), 3'd1, 1);
                end
            endcase
        end
        if (run_results.size() > 0) begin
            run_results[run_results.size() - 1].last_of_run = 1'b1;
        end
        foreach (run_results[i]) begin
            expected_results.push_back(run_results[i]);
        end
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // track accepted transactions on all three channels and check results
    always @(posedge aclk) begin
        console_result_t want;
        if (!aresetn) begin
            in_taken     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tcce_pkg::REG_COLUMNS) begin
                    model_cols = cfg_data;
                end else begin
                    model_rows = cfg_data;
                end
                cfg_writes++;
            end
            if (s_valid && s_ready) begin
                predict_console_results(s_out_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result action %0h glyph %0h len %0h at %0d,%0d",
                             $time, m_action, m_glyph_bytes, m_glyph_length,
                             m_cell_column, m_cell_row);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("action", 32'(want.action), 32'(m_action));
                    compare_field("glyph_bytes", want.glyph_bytes, m_glyph_bytes);
                    compare_field("glyph_length", 32'(want.glyph_length), 32'(m_glyph_length));
                    compare_field("cell_column", 32'(want.cell_column), 32'(m_cell_column));
                    compare_field("cell_row", 32'(want.cell_row), 32'(m_cell_row));
                    compare_field("last_of_run", 32'(want.last_of_run), 32'(m_last_of_run));
                end
            end
            in_taken <= s_valid && s_ready;
            // watchdog: nothing moving on any channel for too long
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, expected_results.size());
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // byte driver: offer the next pending byte, with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
                s_valid    <= 1'b1;
                s_out_byte <= pending_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    task automatic write_register(input logic idx, input logic [7:0] val);
        int unsigned seen;
        @(negedge aclk);
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        wait (cfg_writes != seen);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // hold until every byte is in and every result is out, then let the block settle
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // random text: mostly well-formed glyphs and control bytes, some noise
    task automatic queue_text(input int count);
        int          n;
        int          kind;
        int          len;
        logic [7:0]  lead;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                pending_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                n++;
            end else if (kind < 57) begin
                case ($urandom_range(2))
                    0:       pending_bytes.push_back(tcce_pkg::CH_NEWLINE);
                    1:       pending_bytes.push_back(tcce_pkg::CH_RETURN);
                    default: pending_bytes.push_back(tcce_pkg::CH_BACKSPACE);
                endcase
                n++;
            end else if (kind < 85) begin
                len = $urandom_range(2, 4);
                case (len)
                    2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
                    3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                    default: lead = 8'($urandom_range(8'hF0, 8'hF7));
                endcase
                pending_bytes.push_back(lead);
                for (int i = 1; i < len; i++) begin
                    // now and then a broken sequence with any byte inside
                    if ($urandom_range(9) == 0) begin
                        pending_bytes.push_back(8'($urandom_range(255)));
                    end else begin
                        pending_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    end
                end
                n += len;
            end else begin
                pending_bytes.push_back(8'($urandom_range(255)));
                n++;
            end
        end
    endtask

    initial begin
        logic [7:0] cols_plan[7];
        logic [7:0] rows_plan[7];
        cols_plan = '{8'd255, 8'd0, 8'd1, 8'd255, 8'd3, 8'd80, 8'd7};
        rows_plan = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd2, 8'd25, 8'd5};

        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // tiny screen so wraps and scrolls show up in the opening stream
        write_register(tcce_pkg::REG_COLUMNS, 8'd4);
        write_register(tcce_pkg::REG_ROWS, 8'd3);
        @(posedge aclk);
        foreach (opening_text[i]) begin
            pending_bytes.push_back(opening_text[i]);
        end
        wait_idle();

        for (int phase = 0; phase < 10; phase++) begin
            if (phase < 7) begin
                write_register(tcce_pkg::REG_COLUMNS, cols_plan[phase]);
                write_register(tcce_pkg::REG_ROWS, rows_plan[phase]);
            end else begin
                write_register(tcce_pkg::REG_COLUMNS, 8'($urandom_range(255)));
                write_register(tcce_pkg::REG_ROWS, 8'($urandom_range(255)));
            end
            calm = (phase == 5);
            if (phase == 6) begin
                hold_asked++;
            end
            @(posedge aclk);
            queue_text(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
